/* hw/rtl/rtcte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtcte_pkg;

  localparam int unsigned CFG_INDEX_WIDTH = 4;
  localparam int unsigned CFG_DATA_WIDTH = 8;

  localparam logic [11:0] YEAR_MIN = 12'd1980;
  localparam logic [11:0] YEAR_MAX = 12'd2099;
  localparam logic [11:0] YEAR_2000 = 12'd2000;
  localparam logic [11:0] YEAR_1900 = 12'd1900;
  localparam logic [6:0] CENTURY_19 = 7'd19;
  localparam logic [6:0] CENTURY_20 = 7'd20;
  localparam logic [7:0] CENTURY_19_BIN = 8'd19;
  localparam logic [7:0] CENTURY_20_BIN = 8'd20;
  localparam logic [7:0] CENTURY_19_BCD = 8'h19;
  localparam logic [7:0] CENTURY_20_BCD = 8'h20;
  localparam logic [4:0] HOUR_LIMIT = 5'd23;
  localparam logic [5:0] MINSEC_LIMIT = 6'd59;
  localparam logic [4:0] HOUR_NOON = 5'd12;
  localparam logic [3:0] HOUR_TWELVE = 4'd12;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [7:0] PM_BIT = 8'h80;
  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
  localparam logic [3:0] MONTH_FEB = 4'd2;

  localparam logic [4:0] MONTH_LEN [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_BINARY_MODE = 4'd0,
    CFG_HOUR24_MODE = 4'd1
  } rtcte_cfg_index_t;

  typedef struct packed {
    logic binary_mode;
    logic hour24_mode;
  } rtcte_cfg_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [7:0]  old_century;
  } rtcte_in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] seconds_byte;
    logic [7:0] minutes_byte;
    logic [7:0] hours_byte;
    logic [7:0] day_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
    logic [7:0] century_byte;
    logic       century_write;
  } rtcte_out_t;

  // Tens digit by multiplication with 103/1024, exact for values below 100.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    ones = v - (7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] encode_value(input logic [6:0] v, input logic binary);
    return binary ? {1'b0, v} : to_bcd(v);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rtcte_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rtcte_in_if;
  import rtcte_pkg::*;
  logic      valid;
  logic      ready;
  rtcte_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtcte_out_if;
  import rtcte_pkg::*;
  logic       valid;
  logic       ready;
  rtcte_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtcte_cfg_if;
  import rtcte_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rtc_time_encode_validate.sv */
`timescale 1ns / 1ps
`default_nettype none

// Checks a calendar time (years 1980 to 2099, Gregorian month lengths, 24-hour
// clock) and encodes it into the seven time and century register bytes of an
// MC146818-style RTC, in BCD or binary and in 24-hour or 12-hour form with a PM
// bit, as chosen by the two mode registers. A rejected time gives a word with
// status set and all other fields zero. Each word is taken into the input
// register, and its result is then loaded into the result register, which
// offers it downstream; one word can be taken in every cycle while the result
// side is not stalled, and the result register holds a stalled result while
// the input register keeps the next word.
module rtc_time_encode_validate (
  input  wire         clk,
  input  wire         rst,
  rtcte_in_if.sink    request,
  rtcte_out_if.source result,
  rtcte_cfg_if.sink   cfg
);
  import rtcte_pkg::*;

  rtcte_cfg_t mode;
  logic       stage_valid;
  rtcte_in_t  stage_word;
  rtcte_out_t encoded;
  logic       result_valid;
  rtcte_out_t result_word;
  logic       result_free;

  rtcte_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .mode (mode)
  );

  rtcte_encode u_encode (
    .word_in  (stage_word),
    .mode     (mode),
    .word_out (encoded)
  );

  assign result_free = !result_valid || result.ready;
  assign request.ready = !stage_valid || result_free;
  assign result.valid = result_valid;
  assign result.data = result_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (request.ready) begin
        stage_valid <= request.valid;
      end
      if (result_free) begin
        result_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      stage_word <= request.data;
    end
    if (stage_valid && result_free) begin
      result_word <= encoded;
    end
  end

`ifndef ASSERT_OFF
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status |->
      result_word.seconds_byte == 8'h00 && result_word.minutes_byte == 8'h00
      && result_word.hours_byte == 8'h00 && result_word.day_byte == 8'h00
      && result_word.month_byte == 8'h00 && result_word.year_byte == 8'h00
      && result_word.century_byte == 8'h00 && !result_word.century_write)
    else $error("rejected word carries nonzero fields");

  a_century_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_word.status |->
      result_word.century_byte == CENTURY_19_BIN || result_word.century_byte == CENTURY_20_BIN
      || result_word.century_byte == CENTURY_19_BCD
      || result_word.century_byte == CENTURY_20_BCD)
    else $error("accepted word has a century other than 19 or 20");

  a_date_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_word.status |->
      result_word.month_byte != 8'h00 && result_word.day_byte != 8'h00)
    else $error("accepted word has a zero day or month");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> stage_valid)
    else $error("taken word did not reach the input register");

  a_result_fill: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !result_valid |=> result_valid)
    else $error("input register did not move into an empty result register");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rtcte_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtcte_cfg_regs (
  input  wire               clk,
  input  wire               rst,
  rtcte_cfg_if.sink         cfg,
  output rtcte_pkg::rtcte_cfg_t mode
);
  import rtcte_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode.binary_mode <= 1'b0;
      mode.hour24_mode <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_BINARY_MODE: mode.binary_mode <= cfg.data[0];
        CFG_HOUR24_MODE: mode.hour24_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtcte_encode.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtcte_encode (
  input  rtcte_pkg::rtcte_in_t  word_in,
  input  rtcte_pkg::rtcte_cfg_t mode,
  output rtcte_pkg::rtcte_out_t word_out
);
  import rtcte_pkg::*;

  logic       year_ok;
  logic       month_ok;
  logic       day_ok;
  logic       time_ok;
  logic       leap;
  logic       late_century;
  logic [4:0] month_days;
  logic [6:0] year_low;
  logic [6:0] century;
  logic       pm;
  logic [3:0] hour12;
  logic [7:0] hours_enc;
  logic       century_match;

  always_comb begin
    year_ok = (word_in.year >= YEAR_MIN) && (word_in.year <= YEAR_MAX);
    month_ok = (word_in.month != 4'd0) && (word_in.month <= MONTH_MAX);
    // Inside the accepted year range, 2000 is the only century year and it is leap.
    leap = (word_in.year[1:0] == 2'b00);
    if (!month_ok) begin
      month_days = 5'd0;
    end else if (word_in.month == MONTH_FEB && leap) begin
      month_days = FEB_LEAP_LEN;
    end else begin
      month_days = MONTH_LEN[word_in.month - 4'd1];
    end
    day_ok = (word_in.day != 5'd0) && (word_in.day <= month_days);
    time_ok = (word_in.hour <= HOUR_LIMIT) && (word_in.minute <= MINSEC_LIMIT)
              && (word_in.second <= MINSEC_LIMIT);

    late_century = (word_in.year >= YEAR_2000);
    year_low = late_century ? 7'(word_in.year - YEAR_2000) : 7'(word_in.year - YEAR_1900);
    century = late_century ? CENTURY_20 : CENTURY_19;

    pm = (word_in.hour >= HOUR_NOON);
    hour12 = pm ? 4'(word_in.hour - HOUR_NOON) : word_in.hour[3:0];
    if (hour12 == 4'd0) begin
      hour12 = HOUR_TWELVE;
    end
    if (mode.hour24_mode) begin
      hours_enc = encode_value({2'b00, word_in.hour}, mode.binary_mode);
    end else begin
      hours_enc = encode_value({3'b000, hour12}, mode.binary_mode) | (pm ? PM_BIT : 8'h00);
    end

    if (mode.binary_mode) begin
      century_match = (word_in.old_century == CENTURY_19_BIN)
                      || (word_in.old_century == CENTURY_20_BIN);
    end else begin
      century_match = (word_in.old_century == CENTURY_19_BCD)
                      || (word_in.old_century == CENTURY_20_BCD);
    end

    if (year_ok && month_ok && day_ok && time_ok) begin
      word_out.status = 1'b0;
      word_out.seconds_byte = encode_value({1'b0, word_in.second}, mode.binary_mode);
      word_out.minutes_byte = encode_value({1'b0, word_in.minute}, mode.binary_mode);
      word_out.hours_byte = hours_enc;
      word_out.day_byte = encode_value({2'b00, word_in.day}, mode.binary_mode);
      word_out.month_byte = encode_value({3'b000, word_in.month}, mode.binary_mode);
      word_out.year_byte = encode_value(year_low, mode.binary_mode);
      word_out.century_byte = encode_value(century, mode.binary_mode);
      word_out.century_write = century_match;
    end else begin
      word_out = '0;
      word_out.status = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* verif/rtcte_result_checker.sv */
`timescale 1ns / 1ps

module rtcte_result_checker (
  input  logic        clk,
  input  logic        rst,
  rtcte_in_if         request,
  rtcte_out_if        result,
  rtcte_cfg_if        cfg,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned checked,
  output int unsigned rejected
);
  import rtcte_pkg::*;

  rtcte_cfg_t mode;
  rtcte_out_t expected_words [$];
  rtcte_out_t got;
  rtcte_out_t want;

  initial begin
    failures = 0;
    checked = 0;
    rejected = 0;
    outstanding = 0;
  end

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  function automatic logic [7:0] reg_byte(input int unsigned v, input logic binary);
    return binary ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic rtcte_out_t encode_time(input rtcte_in_t t, input rtcte_cfg_t m);
    rtcte_out_t  r;
    int unsigned yr;
    int unsigned mlen;
    int unsigned h;
    logic        leap;
    logic        ok;
    r = '0;
    yr = t.year;
    mlen = 0;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (t.month >= 1 && t.month <= MONTH_MAX) begin
      mlen = MONTH_LEN[t.month - 1];
      if (t.month == MONTH_FEB && leap) begin
        mlen = FEB_LEAP_LEN;
      end
    end
    ok = yr >= YEAR_MIN && yr <= YEAR_MAX && t.day >= 1 && t.day <= mlen &&
         t.hour <= HOUR_LIMIT && t.minute <= MINSEC_LIMIT && t.second <= MINSEC_LIMIT;
    if (!ok) begin
      r.status = 1'b1;
      return r;
    end
    if (m.hour24_mode) begin
      r.hours_byte = reg_byte(t.hour, m.binary_mode);
    end else begin
      h = t.hour % HOUR_NOON;
      if (h == 0) begin
        h = HOUR_TWELVE;
      end
      r.hours_byte = reg_byte(h, m.binary_mode) | ((t.hour >= HOUR_NOON) ? PM_BIT : 8'h00);
    end
    r.seconds_byte = reg_byte(t.second, m.binary_mode);
    r.minutes_byte = reg_byte(t.minute, m.binary_mode);
    r.day_byte = reg_byte(t.day, m.binary_mode);
    r.month_byte = reg_byte(t.month, m.binary_mode);
    r.year_byte = reg_byte(yr % 100, m.binary_mode);
    r.century_byte = reg_byte(yr / 100, m.binary_mode);
    if (m.binary_mode) begin
      r.century_write = t.old_century == CENTURY_19_BIN || t.old_century == CENTURY_20_BIN;
    end else begin
      r.century_write = t.old_century == CENTURY_19_BCD || t.old_century == CENTURY_20_BCD;
    end
    return r;
  endfunction

  // Results are matched before new words are queued, so a result can never be
  // paired with a word taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      mode.binary_mode = 1'b0;
      mode.hour24_mode = 1'b1;
      outstanding <= 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          CFG_BINARY_MODE: mode.binary_mode = cfg.data[0];
          CFG_HOUR24_MODE: mode.hour24_mode = cfg.data[0];
          default: ;
        endcase
      end
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        got = result.data;
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected result word 0x%0h", got));
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status)
            report($sformatf("word %0d status: got %0h, expected %0h",
                             checked, got.status, want.status));
          if (got.seconds_byte !== want.seconds_byte)
            report($sformatf("word %0d seconds_byte: got 0x%0h, expected 0x%0h",
                             checked, got.seconds_byte, want.seconds_byte));
          if (got.minutes_byte !== want.minutes_byte)
            report($sformatf("word %0d minutes_byte: got 0x%0h, expected 0x%0h",
                             checked, got.minutes_byte, want.minutes_byte));
          if (got.hours_byte !== want.hours_byte)
            report($sformatf("word %0d hours_byte: got 0x%0h, expected 0x%0h",
                             checked, got.hours_byte, want.hours_byte));
          if (got.day_byte !== want.day_byte)
            report($sformatf("word %0d day_byte: got 0x%0h, expected 0x%0h",
                             checked, got.day_byte, want.day_byte));
          if (got.month_byte !== want.month_byte)
            report($sformatf("word %0d month_byte: got 0x%0h, expected 0x%0h",
                             checked, got.month_byte, want.month_byte));
          if (got.year_byte !== want.year_byte)
            report($sformatf("word %0d year_byte: got 0x%0h, expected 0x%0h",
                             checked, got.year_byte, want.year_byte));
          if (got.century_byte !== want.century_byte)
            report($sformatf("word %0d century_byte: got 0x%0h, expected 0x%0h",
                             checked, got.century_byte, want.century_byte));
          if (got.century_write !== want.century_write)
            report($sformatf("word %0d century_write: got %0h, expected %0h",
                             checked, got.century_write, want.century_write));
          checked++;
        end
      end
      if (request.valid === 1'b1 && request.ready === 1'b1) begin
        want = encode_time(request.data, mode);
        if (want.status) begin
          rejected++;
        end
        expected_words.push_back(want);
      end
      outstanding <= expected_words.size();
    end
  end

endmodule

/* verif/rtc_time_encode_validate_test.sv */
`timescale 1ns / 1ps

module rtc_time_encode_validate_test;
  import rtcte_pkg::*;

  localparam time HALF_PERIOD = 5ns;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned STALL_CYCLES = 150;
  localparam int unsigned PHASE_WORDS = 80;
  localparam int unsigned PHASES = 8;
  localparam int unsigned HOLD_PHASE = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIRST_UNUSED = 4'(CFG_HOUR24_MODE + 1);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LAST_INDEX = '1;

  logic        clk = 1'b0;
  logic        rst;
  bit          calm;
  bit          hold_req;
  bit          quiet;
  int unsigned cycle_count;
  int unsigned settings_used;
  int unsigned failures;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned rejected;

  rtcte_in_if  request ();
  rtcte_out_if result ();
  rtcte_cfg_if cfg ();

  rtc_time_encode_validate i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cfg     (cfg)
  );

  rtcte_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .result      (result),
    .cfg         (cfg),
    .failures    (failures),
    .outstanding (outstanding),
    .checked     (checked),
    .rejected    (rejected)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count, outstanding);
    $display("FAIL");
    $finish;
  end

  // The long hold-off is timed here so the sender keeps offering words meanwhile.
  initial begin
    forever begin
      if (hold_req) begin
        result.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic offer(input rtcte_in_t t, input bit idle_ok);
    if (idle_ok && !calm && $urandom_range(0, 3) == 0) begin
      request.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    request.valid <= 1'b1;
    request.data <= t;
    do @(posedge clk); while (request.ready !== 1'b1);
  endtask

  task automatic offer_time(input int unsigned y, input int unsigned mo, input int unsigned d,
                            input int unsigned h, input int unsigned mi, input int unsigned s,
                            input int unsigned oc);
    rtcte_in_t t;
    t.year = 12'(y);
    t.month = 4'(mo);
    t.day = 5'(d);
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    t.old_century = 8'(oc);
    offer(t, 1'b1);
  endtask

  task automatic drain();
    request.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Each setting also writes one random index past the register list, which must be ignored.
  task automatic set_modes(input bit binary, input bit hour24);
    logic [CFG_DATA_WIDTH-1:0]  d;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    for (int k = 0; k < 3; k++) begin
      d = 8'($urandom);
      case (k)
        0: begin
          idx = CFG_BINARY_MODE;
          d[0] = binary;
        end
        1: begin
          idx = CFG_HOUR24_MODE;
          d[0] = hour24;
        end
        default: begin
          idx = 4'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX));
        end
      endcase
      cfg.valid <= 1'b1;
      cfg.index <= idx;
      cfg.data <= d;
      do @(posedge clk); while (cfg.ready !== 1'b1);
    end
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed times with random content, some with one field pushed out of
  // range, and some raw noise over every bit.
  function automatic rtcte_in_t random_time();
    rtcte_in_t   t;
    logic [63:0] raw;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      raw = {$urandom, $urandom};
      t = raw[$bits(rtcte_in_t)-1:0];
      return t;
    end
    t.year = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
    t.month = 4'($urandom_range(1, MONTH_MAX));
    t.day = 5'(($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28));
    t.hour = 5'($urandom_range(0, HOUR_LIMIT));
    t.minute = 6'($urandom_range(0, MINSEC_LIMIT));
    t.second = 6'($urandom_range(0, MINSEC_LIMIT));
    case ($urandom_range(0, 5))
      0: t.old_century = CENTURY_19_BIN;
      1: t.old_century = CENTURY_20_BIN;
      2: t.old_century = CENTURY_19_BCD;
      3: t.old_century = CENTURY_20_BCD;
      default: t.old_century = 8'($urandom);
    endcase
    if (kind == 1) begin
      case ($urandom_range(0, 5))
        0: t.year = 12'($urandom_range(0, 1) ? $urandom_range(YEAR_MAX + 1, 4095)
                                             : $urandom_range(0, YEAR_MIN - 1));
        1: t.month = 4'($urandom_range(0, 1) ? 0 : $urandom_range(MONTH_MAX + 1, 15));
        2: t.day = 5'($urandom_range(0, 1) ? 0 : $urandom_range(29, 31));
        3: t.hour = 5'($urandom_range(HOUR_LIMIT + 1, 31));
        4: t.minute = 6'($urandom_range(MINSEC_LIMIT + 1, 63));
        default: t.second = 6'($urandom_range(MINSEC_LIMIT + 1, 63));
      endcase
    end
    return t;
  endfunction

  initial begin
    request.valid <= 1'b0;
    request.data <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    rst <= 1'b1;
    settings_used = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    offer_time(1980, 1, 1, 0, 0, 0, 8'h19);
    offer_time(2099, 12, 31, 23, 59, 59, 8'h20);
    offer_time(1979, 12, 31, 23, 59, 59, 8'h19);
    offer_time(2100, 1, 1, 0, 0, 0, 8'h20);
    offer_time(0, 0, 0, 0, 0, 0, 0);
    offer_time(4095, 15, 31, 31, 63, 63, 255);
    offer_time(2000, 2, 29, 12, 30, 30, 8'h20);
    offer_time(2096, 2, 29, 1, 2, 3, 8'h20);
    offer_time(1981, 2, 29, 1, 2, 3, 8'h19);
    offer_time(2000, 2, 30, 1, 2, 3, 8'h20);
    offer_time(1980, 4, 31, 4, 5, 6, 8'h19);
    offer_time(1980, 4, 30, 4, 5, 6, 8'h19);
    offer_time(1990, 13, 1, 4, 5, 6, 8'h19);
    offer_time(1990, 6, 0, 4, 5, 6, 8'h19);
    offer_time(1990, 6, 15, 24, 5, 6, 8'h19);
    offer_time(1990, 6, 15, 4, 60, 6, 8'h19);
    offer_time(1990, 6, 15, 4, 5, 60, 8'h19);
    offer_time(2024, 7, 4, 12, 0, 0, 8'h20);
    offer_time(1999, 9, 9, 9, 9, 9, 19);
    offer_time(1999, 11, 30, 21, 45, 10, 8'h20);
    offer_time(2050, 12, 31, 11, 59, 59, 20);
    offer_time(2001, 3, 31, 23, 0, 59, 8'h21);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_modes(1'b1, 1'b1);
        1: set_modes(1'b1, 1'b0);
        2: set_modes(1'b0, 1'b0);
        3: set_modes(1'b0, 1'b1);
        default: set_modes($urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      calm = (p == PHASES - 1);
      if (p == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 16 == 0) begin
          quiet = $urandom_range(0, 2) == 0;
        end
        offer(random_time(), !quiet && !(p == HOLD_PHASE && i < 32));
      end
      drain();
    end

    $display("Checked %0d result words, %0d of them rejected times, over %0d mode settings.",
             checked, rejected, settings_used);
    $display("Modes covered BCD and binary with 24-hour and 12-hour hours, plus a long stall.");
    if (failures == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
